// ===== hdl/htfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfc_pkg: shared types, constants and the CRC function
// Item types, scaling constants and the CRC-8 byte update used by the sensor
// frame check and convert block.
// ----------------------------------------------------------------------------
package htfc_pkg;

    localparam int RAW_W   = 16;
    localparam int SCALE_W = 15;
    localparam int PROD_W  = RAW_W + SCALE_W;
    localparam int READ_W  = 15;
    localparam int DIFF_W  = READ_W + 1;

    localparam logic [7:0]         CRC_POLY    = 8'h31;
    localparam logic [RAW_W-1:0]   STATUS_MASK = 16'hFFFC;
    localparam logic [SCALE_W-1:0] HUM_SCALE   = 15'd12500;
    localparam logic [SCALE_W-1:0] TEMP_SCALE  = 15'd17572;
    localparam logic signed [DIFF_W-1:0] HUM_OFFSET  = 16'sd600;
    localparam logic signed [DIFF_W-1:0] TEMP_OFFSET = 16'sd4685;
    localparam logic signed [DIFF_W-1:0] HUM_MAX     = 16'sd10000;

    localparam logic KIND_HUM  = 1'b0;
    localparam logic KIND_TEMP = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_high;
        logic [7:0] data_low;
        logic [7:0] check_byte;
    } t_in_item;

    typedef struct packed {
        logic                     crc_error;
        logic [RAW_W-1:0]         raw_masked;
        logic signed [READ_W-1:0] reading_centi;
    } t_out_item;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/htfc_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfc_scale: fixed-point scaling of the raw word
// Registers the constant product of the raw word, then subtracts the offset
// and clamps humidity; the result is combinational from the product stage.
// ----------------------------------------------------------------------------
module htfc_scale (
    input  logic                                  i_clk,
    input  logic                                  i_kind,
    input  logic [htfc_pkg::RAW_W-1:0]            i_raw,
    output logic signed [htfc_pkg::READ_W-1:0]    o_reading
);

    logic [htfc_pkg::SCALE_W-1:0] scale;
    logic [htfc_pkg::PROD_W-1:0]  n_prod;
    logic [htfc_pkg::PROD_W-1:0]  r_prod;
    logic                         r_kind;
    logic signed [htfc_pkg::DIFF_W-1:0] whole;
    logic signed [htfc_pkg::DIFF_W-1:0] diff;
    logic signed [htfc_pkg::DIFF_W-1:0] clamped;

    assign scale  = (i_kind == htfc_pkg::KIND_TEMP) ? htfc_pkg::TEMP_SCALE
                                                    : htfc_pkg::HUM_SCALE;
    assign n_prod = htfc_pkg::PROD_W'(i_raw) * htfc_pkg::PROD_W'(scale);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_kind <= i_kind;
    end

    assign whole = $signed({1'b0, r_prod[htfc_pkg::PROD_W-1:htfc_pkg::RAW_W]});

    always_comb begin
        if (r_kind == htfc_pkg::KIND_TEMP) begin
            diff    = whole - htfc_pkg::TEMP_OFFSET;
            clamped = diff;
        end else begin
            diff = whole - htfc_pkg::HUM_OFFSET;
            priority if (diff < 0) begin
                clamped = '0;
            end else if (diff > htfc_pkg::HUM_MAX) begin
                clamped = htfc_pkg::HUM_MAX;
            end else begin
                clamped = diff;
            end
        end
    end

    assign o_reading = clamped[htfc_pkg::READ_W-1:0];

endmodule

// ===== hdl/humidity_temp_frame_check_convert_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_check_convert_core: sensor reply check and conversion
// Checks the CRC-8 of a two-byte sensor reply and scales the masked word to
// hundredths of a percent or a degree.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at each rising edge where start is high and busy is low.
// Busy never rises, so a new item may be offered in every cycle.
// Each result appears on o_result for one cycle with o_strobe high, after
// the stage one, two and three registers, in the order the items came in.
// Throughput is one item per cycle. Stage one runs the CRC over the high
// byte and masks the status bits, stage two finishes the CRC over the low
// byte and registers the constant product, stage three subtracts the
// offset, clamps humidity and zeroes the values of a failed reply.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Reset clears the stage valid bits, so no strobe follows reset until a
// new item is taken. The data registers are not reset.
// ----------------------------------------------------------------------------
module humidity_temp_frame_check_convert_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  htfc_pkg::t_in_item   i_item,
    output logic                 o_strobe,
    output htfc_pkg::t_out_item  o_result
);

    logic accept;

    logic                         r_v1;
    logic [7:0]                   r_crc1;
    logic [7:0]                   r_low1;
    logic [7:0]                   r_chk1;
    logic [htfc_pkg::RAW_W-1:0]   r_raw1;
    logic                         r_kind1;
    logic [7:0]                   n_crc1;

    logic                         r_v2;
    logic                         r_err2;
    logic [htfc_pkg::RAW_W-1:0]   r_raw2;
    logic                         n_err2;

    logic                                 r_v3;
    htfc_pkg::t_out_item                  r_out3;
    htfc_pkg::t_out_item                  n_out3;
    logic signed [htfc_pkg::READ_W-1:0]   reading;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign n_crc1 = htfc_pkg::crc8_byte(8'h00, i_item.data_high);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc1  <= n_crc1;
        r_low1  <= i_item.data_low;
        r_chk1  <= i_item.check_byte;
        r_raw1  <= {i_item.data_high, i_item.data_low} & htfc_pkg::STATUS_MASK;
        r_kind1 <= i_item.kind;
        r_err2  <= n_err2;
        r_raw2  <= r_raw1;
        r_out3  <= n_out3;
    end

    assign n_err2 = htfc_pkg::crc8_byte(r_crc1, r_low1) != r_chk1;

    htfc_scale u_scale (
        .i_clk     (i_clk),
        .i_kind    (r_kind1),
        .i_raw     (r_raw1),
        .o_reading (reading)
    );

    always_comb begin
        n_out3.crc_error = r_err2;
        if (r_err2) begin
            n_out3.raw_masked    = '0;
            n_out3.reading_centi = '0;
        end else begin
            n_out3.raw_masked    = r_raw2;
            n_out3.reading_centi = reading;
        end
    end

    assign o_strobe = r_v3;
    assign o_result = r_out3;

`ifndef SYNTHESIS
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |=> o_strobe)
        else $error("stage two item did not reach the output");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.crc_error) |->
            (o_result.raw_masked == '0 && o_result.reading_centi == '0))
        else $error("failed reply carries nonzero values");

    a_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.raw_masked[1:0] == 2'b00))
        else $error("status bits not cleared");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> ##2 o_strobe)
        else $error("item latency is not three cycles");
`endif

endmodule

// ===== sim/tb_humidity_temp_frame_check_convert_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_humidity_temp_frame_check_convert_core: self-checking bench for the core
// Sends directed sensor replies (scale ends, clamp edges, status bits, check
// byte faults) and then random replies, most with a correct check byte.
// Expected readings are computed here by long division of the reply by the
// CRC polynomial and integer scaling, and each strobed result is compared
// field by field with the oldest expected reading.
// ----------------------------------------------------------------------------
module tb_humidity_temp_frame_check_convert_core;

    localparam int          RANDOM_REPLIES = 1800;
    localparam int          STALL_LIMIT    = 1000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam logic [23:0] POLY_9BIT      = 24'h000131;
    localparam int          HUM_GAIN       = 12500;
    localparam int          HUM_BIAS       = 600;
    localparam int          HUM_CEILING    = 10000;
    localparam int          TEMP_GAIN      = 17572;
    localparam int          TEMP_BIAS      = 4685;

    typedef struct {
        htfc_pkg::t_in_item reply;
        bit                 drain_first;
    } t_reply_req;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    htfc_pkg::t_in_item  i_item  = '0;
    logic                o_strobe;
    htfc_pkg::t_out_item o_result;

    t_reply_req          replies_to_send[$];
    htfc_pkg::t_out_item readings_due[$];
    int                  mismatch_count = 0;
    int                  stall_cycles   = 0;
    int                  gap_left       = 0;
    int                  steady_left    = 0;

    humidity_temp_frame_check_convert_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] reply_remainder(input logic [7:0] hi,
                                                   input logic [7:0] lo,
                                                   input logic [7:0] chk);
        logic [23:0] rem;
        rem = {hi, lo, chk};
        for (int b = 0; b < 16; b++) begin
            if (rem[23 - b]) begin
                rem = rem ^ (POLY_9BIT << (15 - b));
            end
        end
        return rem[7:0];
    endfunction

    function automatic htfc_pkg::t_out_item convert_reply(input htfc_pkg::t_in_item reply);
        htfc_pkg::t_out_item res;
        logic [15:0]         raw;
        int                  centi;
        res = '0;
        if (reply_remainder(reply.data_high, reply.data_low, reply.check_byte) != 8'h00) begin
            res.crc_error = 1'b1;
            return res;
        end
        raw = {reply.data_high, reply.data_low} & 16'hFFFC;
        if (reply.kind == htfc_pkg::KIND_TEMP) begin
            centi = int'((32'(raw) * TEMP_GAIN) >> 16) - TEMP_BIAS;
        end else begin
            centi = int'((32'(raw) * HUM_GAIN) >> 16) - HUM_BIAS;
            if (centi < 0) begin
                centi = 0;
            end
            if (centi > HUM_CEILING) begin
                centi = HUM_CEILING;
            end
        end
        res.raw_masked    = raw;
        res.reading_centi = centi[14:0];
        return res;
    endfunction

    task automatic queue_reply(input logic kind, input logic [7:0] hi, input logic [7:0] lo,
                               input logic [7:0] chk, input bit drain_first);
        t_reply_req req;
        req.reply       = '{kind: kind, data_high: hi, data_low: lo, check_byte: chk};
        req.drain_first = drain_first;
        replies_to_send.push_back(req);
    endtask

    task automatic queue_good_reply(input logic kind, input logic [7:0] hi,
                                    input logic [7:0] lo);
        queue_reply(kind, hi, lo, reply_remainder(hi, lo, 8'h00), 1'b0);
    endtask

    always @(posedge i_clk) begin : drive_proc
        t_reply_req req;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                readings_due.push_back(convert_reply(i_item));
            end
            if (!start || !busy) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end else if (replies_to_send.size() != 0 &&
                             (!replies_to_send[0].drain_first || readings_due.size() == 0)) begin
                    req = replies_to_send.pop_front();
                    i_item <= req.reply;
                    start  <= 1'b1;
                    if (steady_left != 0) begin
                        steady_left = steady_left - 1;
                        gap_left    = 0;
                    end else begin
                        case ($urandom_range(0, 99)) inside
                            [0:54]:  gap_left = 0;
                            [55:84]: gap_left = $urandom_range(1, 3);
                            [85:96]: gap_left = $urandom_range(4, 8);
                            default: gap_left = $urandom_range(20, 60);
                        endcase
                        if ($urandom_range(0, 39) == 0) begin
                            steady_left = $urandom_range(20, 120);
                        end
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_proc
        htfc_pkg::t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (readings_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual err=%0b raw=%0d centi=%0d",
                         $time, o_result.crc_error, o_result.raw_masked,
                         o_result.reading_centi);
                mismatch_count++;
            end else begin
                want = readings_due.pop_front();
                if (o_result.crc_error !== want.crc_error) begin
                    $display("%0t: crc_error mismatch: expected %0b, actual %0b",
                             $time, want.crc_error, o_result.crc_error);
                    mismatch_count++;
                end
                if (o_result.raw_masked !== want.raw_masked) begin
                    $display("%0t: raw_masked mismatch: expected %0d, actual %0d",
                             $time, want.raw_masked, o_result.raw_masked);
                    mismatch_count++;
                end
                if (o_result.reading_centi !== want.reading_centi) begin
                    $display("%0t: reading_centi mismatch: expected %0d, actual %0d",
                             $time, want.reading_centi, o_result.reading_centi);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : main_proc
        logic        kind;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  chk;
        logic [23:0] flip;
        int          pick;

        // Scale ends, clamp edges and status bits, all with a correct check byte.
        queue_good_reply(htfc_pkg::KIND_HUM, 8'h00, 8'h00);
        queue_good_reply(htfc_pkg::KIND_TEMP, 8'h00, 8'h00);
        queue_good_reply(htfc_pkg::KIND_HUM, 8'hFF, 8'hFF);
        queue_good_reply(htfc_pkg::KIND_TEMP, 8'hFF, 8'hFF);
        queue_good_reply(htfc_pkg::KIND_HUM, 8'h0C, 8'h4C);
        queue_good_reply(htfc_pkg::KIND_HUM, 8'h0C, 8'h50);
        queue_good_reply(htfc_pkg::KIND_HUM, 8'hD9, 8'h14);
        queue_good_reply(htfc_pkg::KIND_HUM, 8'hD9, 8'h18);
        queue_good_reply(htfc_pkg::KIND_TEMP, 8'h44, 8'h40);
        queue_good_reply(htfc_pkg::KIND_TEMP, 8'h44, 8'h44);
        queue_good_reply(htfc_pkg::KIND_HUM, 8'h66, 8'h67);
        queue_good_reply(htfc_pkg::KIND_TEMP, 8'h66, 8'h67);
        // Check byte faults, including a check byte belonging to other data.
        queue_reply(htfc_pkg::KIND_HUM, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_reply(htfc_pkg::KIND_TEMP, 8'h80, 8'h00, reply_remainder(8'h00, 8'h00, 8'h00),
                    1'b0);
        for (int b = 0; b < 8; b++) begin
            hi = 8'h5A + 8'(b * 17);
            lo = 8'hC3 ^ 8'(b * 29);
            queue_reply(b[0], hi, lo, reply_remainder(hi, lo, 8'h00) ^ (8'h01 << b), 1'b0);
        end

        for (int n = 0; n < RANDOM_REPLIES; n++) begin
            kind = 1'($urandom_range(0, 1));
            hi   = 8'($urandom_range(0, 255));
            lo   = 8'($urandom_range(0, 255));
            chk  = reply_remainder(hi, lo, 8'h00);
            pick = int'($urandom_range(0, 99));
            if (pick >= 85) begin
                chk = 8'($urandom_range(0, 255));
            end else if (pick >= 70) begin
                flip = 24'h000001 << $urandom_range(0, 23);
                {hi, lo, chk} = {hi, lo, chk} ^ flip;
            end
            queue_reply(kind, hi, lo, chk, n == 0 || $urandom_range(0, 299) == 0);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (replies_to_send.size() != 0 || start || readings_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== humidity_temp_frame_check_convert_core.f =====
hdl/htfc_pkg.sv
hdl/htfc_scale.sv
hdl/humidity_temp_frame_check_convert_core.sv
sim/tb_humidity_temp_frame_check_convert_core.sv
